// ===== hw/rtl/write_ring_with_offset_lookup_macros.svh =====
// ----------------------------------------------------------------------------
// write ring assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef WRITE_RING_WITH_OFFSET_LOOKUP_MACROS_SVH
`define WRITE_RING_WITH_OFFSET_LOOKUP_MACROS_SVH

// same-cycle implication
`define WROL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WROL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wrol_pkg.sv =====
// ----------------------------------------------------------------------------
// wrol_pkg
// field widths, request codes and the cell response type of the write ring
// ----------------------------------------------------------------------------
package wrol_pkg;

  localparam int LEN_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int OFFS_W   = 20;
  localparam int SLOT_W   = 4;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  // response of one cell when the find token ends there
  typedef struct packed {
    logic                done;
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    inner;
  } cell_rsp_t;

endpackage

// ===== hw/rtl/wrol_cell.sv =====
// ----------------------------------------------------------------------------
// wrol_cell
// one ring slot: holds a record and passes the find token to its neighbor
// ----------------------------------------------------------------------------
module wrol_cell #(
  parameter int                           CNT_W = 5,
  parameter logic [wrol_pkg::SLOT_W-1:0]  SLOT  = '0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hold,
  input  logic                          wr_en,
  input  logic [wrol_pkg::LEN_W-1:0]    wr_len,
  input  logic [wrol_pkg::HANDLE_W-1:0] wr_handle,
  output logic [wrol_pkg::HANDLE_W-1:0] old_handle,
  input  logic                          tok_in_v,
  input  logic [wrol_pkg::OFFS_W-1:0]   tok_in_rem,
  input  logic [CNT_W-1:0]              tok_in_left,
  output logic                          tok_out_v,
  output logic [wrol_pkg::OFFS_W-1:0]   tok_out_rem,
  output logic [CNT_W-1:0]              tok_out_left,
  output wrol_pkg::cell_rsp_t           rsp
);

  logic [wrol_pkg::LEN_W-1:0]    len_r;
  logic [wrol_pkg::HANDLE_W-1:0] handle_r;
  logic                          tok_v_r, tok_v_nxt;
  logic [wrol_pkg::OFFS_W-1:0]   tok_rem_r, tok_rem_nxt;
  logic [CNT_W-1:0]              tok_left_r, tok_left_nxt;
  logic                          in_range, found, finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      handle_r <= '0;
    end else if (wr_en) begin
      len_r    <= wr_len;
      handle_r <= wr_handle;
    end
  end

  assign old_handle = wr_en ? handle_r : '0;

  assign in_range = tok_rem_r < wrol_pkg::OFFS_W'(len_r);
  assign found    = (tok_left_r != '0) && (len_r != '0) && in_range;
  assign finish   = (tok_left_r == '0) || (len_r == '0) || in_range;

  // token moves on to the next slot with the length taken off
  assign tok_out_v    = tok_v_r && !hold && !finish;
  assign tok_out_rem  = tok_rem_r - wrol_pkg::OFFS_W'(len_r);
  assign tok_out_left = tok_left_r - CNT_W'(1);

  always_comb begin
    rsp = '0;
    if (tok_v_r && !hold && finish) begin
      rsp.done = 1'b1;
      if (found) begin
        rsp.hit    = 1'b1;
        rsp.handle = handle_r;
        rsp.slot   = SLOT;
        rsp.inner  = tok_rem_r[wrol_pkg::LEN_W-1:0];
      end
    end
  end

  always_comb begin
    tok_v_nxt    = tok_v_r;
    tok_rem_nxt  = tok_rem_r;
    tok_left_nxt = tok_left_r;
    if (!hold) begin
      tok_v_nxt    = tok_in_v;
      tok_rem_nxt  = tok_in_rem;
      tok_left_nxt = tok_in_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_rem_r  <= tok_rem_nxt;
    tok_left_r <= tok_left_nxt;
  end

endmodule

// ===== hw/rtl/write_ring_with_offset_lookup.sv =====
// ----------------------------------------------------------------------------
// write_ring_with_offset_lookup
// ring of DEPTH write records with lookup of the record holding a byte offset
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, kind, size, handle,  | request
//          | byte_pos                                |
//  out     | out_valid/out_ready, kind_echo, hit,    | result
//          | handle_out, slot_out, byte_in_entry     |
//
//  an add transaction is answered at the clock after it is taken
//  a find sends a token around the row of cells starting at the oldest slot,
//    one cell per cycle while hold does not freeze the walk
//  one request is in flight at a time; in_ready drops during a find walk
//  a result waiting on out_ready holds in_ready low until it is taken
//  synchronous active-low reset empties the ring; no clearing pass
//
module write_ring_with_offset_lookup #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [wrol_pkg::LEN_W-1:0]    in_entry_size,
  input  logic [wrol_pkg::HANDLE_W-1:0] in_entry_handle,
  input  logic [wrol_pkg::OFFS_W-1:0]   in_byte_pos,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind_echo,
  output logic                          out_hit,
  output logic [wrol_pkg::HANDLE_W-1:0] out_handle_out,
  output logic [wrol_pkg::SLOT_W-1:0]   out_slot_out,
  output logic [wrol_pkg::LEN_W-1:0]    out_byte_in_entry
);

`include "write_ring_with_offset_lookup_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // ring pointers
  logic [IDX_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [IDX_W-1:0] old_slot_r, old_slot_nxt;
  logic             ring_full_r, ring_full_nxt;
  logic [IDX_W-1:0] wr_slot_inc;

  // control
  logic busy_r, busy_nxt;
  logic hold, accept, add_go, find_go;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_hit_r;
  logic [wrol_pkg::HANDLE_W-1:0] out_handle_r;
  logic [wrol_pkg::SLOT_W-1:0]   out_slot_r;
  logic [wrol_pkg::LEN_W-1:0]    out_inner_r;

  // find setup
  logic [CNT_W:0]   cnt_wrap;
  logic [CNT_W-1:0] rec_count;

  // cell row wiring
  logic                          pass_v    [DEPTH];
  logic [wrol_pkg::OFFS_W-1:0]   pass_rem  [DEPTH];
  logic [CNT_W-1:0]              pass_left [DEPTH];
  logic [wrol_pkg::HANDLE_W-1:0] old_h     [DEPTH];
  wrol_pkg::cell_rsp_t           rsp_w     [DEPTH];
  logic [DEPTH-1:0]              tok_vec;
  wrol_pkg::cell_rsp_t           rsp_all;
  logic [wrol_pkg::HANDLE_W-1:0] evict_h;

  // a result waiting with nobody taking it freezes the walk
  assign hold     = out_valid_r && !out_ready;
  assign in_ready = !busy_r && !hold;
  assign accept   = in_valid && in_ready;
  assign add_go   = accept && (in_kind == wrol_pkg::KIND_ADD);
  assign find_go  = accept && (in_kind == wrol_pkg::KIND_FIND);

  assign wr_slot_inc = (wr_slot_r == IDX_W'(DEPTH - 1)) ? '0 : wr_slot_r + IDX_W'(1);

  // records stored, from oldest to newest
  assign cnt_wrap  = (CNT_W+1)'(wr_slot_r) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(old_slot_r);
  always_comb begin
    if (ring_full_r) begin
      rec_count = CNT_W'(DEPTH);
    end else if (wr_slot_r >= old_slot_r) begin
      rec_count = CNT_W'(wr_slot_r) - CNT_W'(old_slot_r);
    end else begin
      rec_count = CNT_W'(cnt_wrap);
    end
  end

  // row of cells, each handing the token to the next slot
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int PREV = (i + DEPTH - 1) % DEPTH;
    logic                        inject;
    logic                        t_in_v;
    logic [wrol_pkg::OFFS_W-1:0] t_in_rem;
    logic [CNT_W-1:0]            t_in_left;

    assign inject    = find_go && (old_slot_r == IDX_W'(i));
    assign t_in_v    = inject || pass_v[PREV];
    assign t_in_rem  = inject ? in_byte_pos : pass_rem[PREV];
    assign t_in_left = inject ? rec_count : pass_left[PREV];

    wrol_cell #(
      .CNT_W (CNT_W),
      .SLOT  (wrol_pkg::SLOT_W'(i))
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .hold         (hold),
      .wr_en        (add_go && (wr_slot_r == IDX_W'(i))),
      .wr_len       (in_entry_size),
      .wr_handle    (in_entry_handle),
      .old_handle   (old_h[i]),
      .tok_in_v     (t_in_v),
      .tok_in_rem   (t_in_rem),
      .tok_in_left  (t_in_left),
      .tok_out_v    (pass_v[i]),
      .tok_out_rem  (pass_rem[i]),
      .tok_out_left (pass_left[i]),
      .rsp          (rsp_w[i])
    );

    assign tok_vec[i] = pass_v[i] || rsp_w[i].done;
  end

  // only one cell answers at a time, so the answers merge by or
  always_comb begin
    rsp_all = '0;
    evict_h = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rsp_all = wrol_pkg::cell_rsp_t'(rsp_all | rsp_w[i]);
      evict_h = evict_h | old_h[i];
    end
  end

  // pointer update on add
  always_comb begin
    wr_slot_nxt   = wr_slot_r;
    old_slot_nxt  = old_slot_r;
    ring_full_nxt = ring_full_r;
    if (add_go) begin
      wr_slot_nxt = wr_slot_inc;
      if (ring_full_r) begin
        old_slot_nxt = wr_slot_inc;
      end else if (wr_slot_inc == old_slot_r) begin
        ring_full_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (find_go) begin
      busy_nxt = 1'b1;
    end else if (rsp_all.done) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (add_go || rsp_all.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r   <= '0;
      old_slot_r  <= '0;
      ring_full_r <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_slot_r   <= wr_slot_nxt;
      old_slot_r  <= old_slot_nxt;
      ring_full_r <= ring_full_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: add answers at once, find when its token stops
  always_ff @(posedge clk) begin
    if (add_go) begin
      out_kind_r   <= wrol_pkg::KIND_ADD;
      out_hit_r    <= ring_full_r;
      out_handle_r <= ring_full_r ? evict_h : '0;
      out_slot_r   <= wrol_pkg::SLOT_W'(wr_slot_r);
      out_inner_r  <= '0;
    end else if (rsp_all.done) begin
      out_kind_r   <= wrol_pkg::KIND_FIND;
      out_hit_r    <= rsp_all.hit;
      out_handle_r <= rsp_all.handle;
      out_slot_r   <= rsp_all.slot;
      out_inner_r  <= rsp_all.inner;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind_echo     = out_kind_r;
  assign out_hit           = out_hit_r;
  assign out_handle_out    = out_handle_r;
  assign out_slot_out      = out_slot_r;
  assign out_byte_in_entry = out_inner_r;

  // checks
  `WROL_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec), "more than one find token in the ring")
  `WROL_ASSERT_NOW(a_done_busy, rsp_all.done, busy_r, "cell answered with no find in flight")
  `WROL_ASSERT_NOW(a_full_ptrs, ring_full_r, wr_slot_r == old_slot_r, "split full pointers")
  `WROL_ASSERT_NEXT(a_evict_hit, add_go && ring_full_r, out_valid && out_hit, "no eviction")

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// write ring with offset lookup testbench
// drives add and find requests with bursty valid and a patterned ready,
// predicts untyped results from a private copy of the ring, and compares each
// result transaction field by field in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W    = wrol_pkg::LEN_W;
  localparam int HANDLE_W = wrol_pkg::HANDLE_W;
  localparam int OFFS_W   = wrol_pkg::OFFS_W;
  localparam int SLOT_W   = wrol_pkg::SLOT_W;

  localparam int RING_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_LIMIT   = 4000;

  // one request as presented on the input channel
  typedef struct packed {
    logic                kind;
    logic [LEN_W-1:0]    size;
    logic [HANDLE_W-1:0] handle;
    logic [OFFS_W-1:0]   offset;
  } ring_req_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic                kind;
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    inner;
  } ring_rsp_t;

  // directed row: request plus an optional hand-written result
  typedef struct packed {
    ring_req_t req;
    logic      typed;
    ring_rsp_t rsp;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_kind = wrol_pkg::KIND_ADD;
  logic [LEN_W-1:0]    in_entry_size = '0;
  logic [HANDLE_W-1:0] in_entry_handle = '0;
  logic [OFFS_W-1:0]   in_byte_pos = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_kind_echo;
  logic                out_hit;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [LEN_W-1:0]    out_byte_in_entry;

  // shadow copy of the ring
  logic [LEN_W-1:0]    rec_len    [RING_DEPTH];
  logic [HANDLE_W-1:0] rec_handle [RING_DEPTH];
  int unsigned         wr_slot;
  int unsigned         old_slot;
  bit                  ring_full;

  ring_rsp_t pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;

  write_ring_with_offset_lookup #(
    .DEPTH(RING_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_size    (in_entry_size),
    .in_entry_handle  (in_entry_handle),
    .in_byte_pos      (in_byte_pos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind_echo    (out_kind_echo),
    .out_hit          (out_hit),
    .out_handle_out   (out_handle_out),
    .out_slot_out     (out_slot_out),
    .out_byte_in_entry(out_byte_in_entry)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ring after reset: empty, all records zero
  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      rec_len[i]    = '0;
      rec_handle[i] = '0;
    end
    wr_slot   = 0;
    old_slot  = 0;
    ring_full = 1'b0;
  end

  // number of records currently stored
  function automatic int unsigned stored_records();
    return ring_full ? RING_DEPTH : (wr_slot + RING_DEPTH - old_slot) % RING_DEPTH;
  endfunction

  // bytes covered by the first n reachable records, oldest first;
  // a zero-length record ends the reachable data
  function automatic logic [31:0] walk_bytes(int unsigned n);
    int unsigned cnt;
    int unsigned idx;
    logic [31:0] sum;
    cnt = stored_records();
    idx = old_slot;
    sum = '0;
    for (int unsigned k = 0; k < cnt && k < n; k++) begin
      if (rec_len[idx] == '0) break;
      sum += rec_len[idx];
      idx = (idx + 1) % RING_DEPTH;
    end
    return sum;
  endfunction

  // apply one accepted request to the shadow ring and return its result
  function automatic ring_rsp_t ring_apply(ring_req_t req);
    ring_rsp_t   rsp;
    int unsigned cnt;
    int unsigned idx;
    logic [31:0] start;
    rsp      = '0;
    rsp.kind = req.kind;
    if (req.kind == wrol_pkg::KIND_ADD) begin
      // full ring: the slot being written holds the oldest record
      if (ring_full) begin
        rsp.hit    = 1'b1;
        rsp.handle = rec_handle[wr_slot];
      end
      rec_len[wr_slot]    = req.size;
      rec_handle[wr_slot] = req.handle;
      rsp.slot            = SLOT_W'(wr_slot);
      wr_slot             = (wr_slot + 1) % RING_DEPTH;
      if (ring_full) old_slot = wr_slot;
      else if (wr_slot == old_slot) ring_full = 1'b1;
    end else begin
      cnt   = stored_records();
      idx   = old_slot;
      start = '0;
      for (int unsigned k = 0; k < cnt; k++) begin
        // zero-length record stops the walk as a miss
        if (rec_len[idx] == '0) break;
        // strict compare: a boundary offset lands in the later record
        if (32'(req.offset) < start + 32'(rec_len[idx])) begin
          rsp.hit    = 1'b1;
          rsp.handle = rec_handle[idx];
          rsp.slot   = SLOT_W'(idx);
          rsp.inner  = LEN_W'(32'(req.offset) - start);
          break;
        end
        start += rec_len[idx];
        idx = (idx + 1) % RING_DEPTH;
      end
    end
    return rsp;
  endfunction

  function automatic void table_row(logic kind, logic [LEN_W-1:0] size,
                                    logic [HANDLE_W-1:0] handle, logic [OFFS_W-1:0] offset,
                                    logic typed, logic hit, logic [HANDLE_W-1:0] hout,
                                    logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] inner);
    stim_row_t row;
    row.req   = '{kind: kind, size: size, handle: handle, offset: offset};
    row.typed = typed;
    row.rsp   = '{kind: kind, hit: hit, handle: hout, slot: slot, inner: inner};
    directed_rows.push_back(row);
  endfunction

  // directed table: typed results where they are obvious, predictor elsewhere
  function automatic void build_table();
    // empty ring: both ends of the offset range miss
    table_row(wrol_pkg::KIND_FIND, '0, '0, '0,        1, 0, '0, '0, '0);
    table_row(wrol_pkg::KIND_FIND, '1, '1, 20'hFFFFF, 1, 0, '0, '0, '0);
    // largest record, largest handle, into slot 0
    table_row(wrol_pkg::KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1, 0, '0, 4'd0, '0);
    table_row(wrol_pkg::KIND_FIND, '0, '0, 20'h00000, 1, 1, 32'hFFFF_FFFF, 4'd0, 16'h0000);
    table_row(wrol_pkg::KIND_FIND, '0, '0, 20'h0FFFE, 1, 1, 32'hFFFF_FFFF, 4'd0, 16'hFFFE);
    // just past the end of the data
    table_row(wrol_pkg::KIND_FIND, '1, '1, 20'h0FFFF, 1, 0, '0, '0, '0);
    // one-byte record with handle zero in slot 1
    table_row(wrol_pkg::KIND_ADD, 16'd1, '0, '0,      1, 0, '0, 4'd1, '0);
    // offset on the boundary belongs to the later record at byte 0
    table_row(wrol_pkg::KIND_FIND, '0, '0, 20'h0FFFF, 1, 1, '0, 4'd1, '0);
    // zero-length record in slot 2, then a real one behind it
    table_row(wrol_pkg::KIND_ADD, 16'd0, 32'hA5A5_A5A5, '0, 1, 0, '0, 4'd2, '0);
    table_row(wrol_pkg::KIND_ADD, 16'd5, 32'h5A5A_5A5A, '0, 1, 0, '0, 4'd3, '0);
    // the zero-length record hides everything after it
    table_row(wrol_pkg::KIND_FIND, '0, '0, 20'h10000, 1, 0, '0, '0, '0);
    table_row(wrol_pkg::KIND_FIND, '0, '0, 20'h10005, 1, 0, '0, '0, '0);
    // fill the remaining slots, predictor checked
    for (int k = 4; k < RING_DEPTH; k++)
      table_row(wrol_pkg::KIND_ADD, LEN_W'(k * 911 + 3),
                HANDLE_W'(32'h1000_0000 + k * 32'h0101_0101),
                OFFS_W'(k), 0, 0, '0, '0, '0);
    // full ring: the add evicts slot 0
    table_row(wrol_pkg::KIND_ADD, 16'd7, 32'hDEAD_0001, '0, 1, 1, 32'hFFFF_FFFF, 4'd0, '0);
    // oldest record is now the one-byte record in slot 1
    table_row(wrol_pkg::KIND_FIND, '0, '0, 20'h00000, 1, 1, '0, 4'd1, '0);
  endfunction

  // random request shaped by the current ring contents
  function automatic ring_req_t random_request();
    ring_req_t   req;
    int unsigned pick;
    logic [31:0] span;
    req.kind   = $urandom_range(0, 1) ? wrol_pkg::KIND_FIND : wrol_pkg::KIND_ADD;
    req.handle = $urandom;
    req.offset = OFFS_W'($urandom_range(0, (1 << OFFS_W) - 1));
    // mostly short records, a few large and a few zero-length
    pick = $urandom_range(0, 99);
    if (pick < 3)       req.size = '0;
    else if (pick < 13) req.size = LEN_W'($urandom_range(0, 65535));
    else if (pick < 16) req.size = '1;
    else                req.size = LEN_W'($urandom_range(1, 300));
    if (req.kind == wrol_pkg::KIND_FIND) begin
      span = walk_bytes(RING_DEPTH);
      pick = $urandom_range(0, 99);
      // full-range offsets keep their random value
      if (pick >= 10) begin
        if (pick < 35)      req.offset = OFFS_W'(walk_bytes($urandom_range(0, RING_DEPTH)));
        else if (pick < 45) req.offset = OFFS_W'(span == 0 ? 32'd0 : span - 1);
        else                req.offset = OFFS_W'($urandom_range(0, span + 3));
      end
    end
    return req;
  endfunction

  // present one request, wait for the handshake, record what must come back
  task automatic issue(ring_req_t req, logic typed, ring_rsp_t typed_rsp, bit last);
    ring_rsp_t predicted;
    in_valid        <= 1'b1;
    in_kind         <= req.kind;
    in_entry_size   <= req.size;
    in_entry_handle <= req.handle;
    in_byte_pos     <= req.offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transaction taken at this edge
    predicted = ring_apply(req);
    pending_results.push_back(typed ? typed_rsp : predicted);
    burst_left--;
    if (last) begin
      in_valid <= 1'b0;
    end else if (burst_left <= 0) begin
      // gap between bursts; valid also drops after the last request
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
  endtask

  // receiver: windows of always-ready, random stall, or a rotating pattern
  initial begin
    int unsigned mode;
    logic [31:0] pattern;
    int unsigned phase;
    forever begin
      mode    = $urandom_range(0, 3);
      pattern = $urandom | 32'd1;
      phase   = 0;
      repeat (64) begin
        @(posedge clk);
        case (mode)
          0, 1: out_ready <= 1'b1;
          2: out_ready <= ($urandom_range(0, 2) != 0);
          default: begin
            out_ready <= pattern[phase];
            phase = (phase + 1) % 32;
          end
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker: in-order compare against the oldest expectation
  always @(posedge clk) begin
    ring_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind_echo",     32'(want.kind),   32'(out_kind_echo));
        check_field("hit",           32'(want.hit),    32'(out_hit));
        check_field("handle_out",    32'(want.handle), 32'(out_handle_out));
        check_field("slot_out",      32'(want.slot),   32'(out_slot_out));
        check_field("byte_in_entry", 32'(want.inner),  32'(out_byte_in_entry));
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    build_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 6);
    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp, 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      issue(random_request(), 1'b0, '0, i == RANDOM_ITEMS - 1);
    // drain, then allow a full walk for anything unexpected
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RING_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
